[hdl/mhc_pkg.sv]
// Package for the magnetometer heading calibration block.
// Holds the mode and state codes, fixed widths, control structs and the arctangent table.
// No dependencies.
package mhc_pkg;

   // Default values of the top-level parameters
   localparam int CORDIC_STEPS_DEFAULT    = 16;
   localparam int ANGLE_FRAC_BITS_DEFAULT = 6;

   // Field widths of the transactions
   localparam int MAG_W  = 16;
   localparam int DIFF_W = MAG_W + 1;
   localparam int HEAD_W = 15;

   // Internal angle units are 2^-16 degree
   localparam int DEG_FRAC = 16;

   // Rotator datapath: a 17-bit difference scaled by 2^16, with room for gain and sqrt(2)
   localparam int CORDIC_W = 36;

   // Angle accumulator, in 2^-16 degree, and the sum with 180 degrees
   localparam int ANGLE_W = 28;
   localparam int TOTAL_W = ANGLE_W + 1;

   // Non-negative clamped total and its rounding sum
   localparam int ROUND_W = 26;

   // Arctangent table
   localparam int TBL_LEN   = 24;
   localparam int TBL_IDX_W = 5;

   localparam logic signed [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180 * (1 << DEG_FRAC));
   localparam logic signed [TOTAL_W-1:0] DEG_360 = TOTAL_W'(360 * (1 << DEG_FRAC));

   // Request modes carried in tuser
   typedef enum logic [1:0] {
      MODE_CLEAR   = 2'd0,
      MODE_FOLD    = 2'd1,
      MODE_FINISH  = 2'd2,
      MODE_HEADING = 2'd3
   } mode_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ITER,
      ST_ROUND,
      ST_DONE
   } state_type;

   // Commands to the calibration store
   typedef struct packed {
      logic clear;
      logic fold;
      logic finish;
   } cal_ctrl_type;

   // Commands to the rotator
   typedef struct packed {
      logic load;
      logic iterate;
   } cordic_ctrl_type;

   // atan(2^-i) in 2^-16 degree, rounded to nearest
   function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [TBL_IDX_W-1:0] idx);
      logic signed [ANGLE_W-1:0] val;
      unique case (idx)
         5'd0:    val = 28'sd2949120;
         5'd1:    val = 28'sd1740967;
         5'd2:    val = 28'sd919879;
         5'd3:    val = 28'sd466945;
         5'd4:    val = 28'sd234379;
         5'd5:    val = 28'sd117304;
         5'd6:    val = 28'sd58666;
         5'd7:    val = 28'sd29335;
         5'd8:    val = 28'sd14668;
         5'd9:    val = 28'sd7334;
         5'd10:   val = 28'sd3667;
         5'd11:   val = 28'sd1833;
         5'd12:   val = 28'sd917;
         5'd13:   val = 28'sd458;
         5'd14:   val = 28'sd229;
         5'd15:   val = 28'sd115;
         5'd16:   val = 28'sd57;
         5'd17:   val = 28'sd29;
         5'd18:   val = 28'sd14;
         5'd19:   val = 28'sd7;
         5'd20:   val = 28'sd4;
         5'd21:   val = 28'sd2;
         5'd22:   val = 28'sd1;
         default: val = 28'sd0;
      endcase
      return val;
   endfunction

endpackage

[hdl/mhc_cal_store.sv]
// Calibration store: per-axis minimum and maximum and the hard-iron offsets.
// Depends on mhc_pkg.
module mhc_cal_store
   import mhc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cal_ctrl_type            ctrl,
   input  logic signed [MAG_W-1:0] mag_x,
   input  logic signed [MAG_W-1:0] mag_y,
   input  logic signed [MAG_W-1:0] mag_z,
   output logic signed [MAG_W-1:0] off_x,
   output logic signed [MAG_W-1:0] off_y,
   output logic signed [MAG_W-1:0] off_z
);

   logic signed [MAG_W-1:0] min_x_ff, min_y_ff, min_z_ff;
   logic signed [MAG_W-1:0] max_x_ff, max_y_ff, max_z_ff;
   logic signed [MAG_W-1:0] min_x_in, min_y_in, min_z_in;
   logic signed [MAG_W-1:0] max_x_in, max_y_in, max_z_in;
   logic signed [MAG_W-1:0] off_x_ff, off_y_ff, off_z_ff;
   logic signed [MAG_W-1:0] off_x_in, off_y_in, off_z_in;

   // Midpoint of an axis, halved with truncation toward zero
   function automatic logic signed [MAG_W-1:0] midpoint(input logic signed [MAG_W-1:0] lo,
                                                        input logic signed [MAG_W-1:0] hi);
      logic signed [DIFF_W-1:0] sum;
      logic signed [DIFF_W-1:0] adj;
      sum = DIFF_W'(lo) + DIFF_W'(hi);
      adj = sum + DIFF_W'(sum[DIFF_W-1]);
      return adj[DIFF_W-1:1];
   endfunction

   // Next values of the extremes and offsets
   always_comb begin
      min_x_in = min_x_ff;
      min_y_in = min_y_ff;
      min_z_in = min_z_ff;
      max_x_in = max_x_ff;
      max_y_in = max_y_ff;
      max_z_in = max_z_ff;
      off_x_in = off_x_ff;
      off_y_in = off_y_ff;
      off_z_in = off_z_ff;
      if (ctrl.clear) begin
         min_x_in = '0;
         min_y_in = '0;
         min_z_in = '0;
         max_x_in = '0;
         max_y_in = '0;
         max_z_in = '0;
         off_x_in = '0;
         off_y_in = '0;
         off_z_in = '0;
      end else if (ctrl.fold) begin
         if (mag_x < min_x_ff) min_x_in = mag_x;
         if (mag_x > max_x_ff) max_x_in = mag_x;
         if (mag_y < min_y_ff) min_y_in = mag_y;
         if (mag_y > max_y_ff) max_y_in = mag_y;
         if (mag_z < min_z_ff) min_z_in = mag_z;
         if (mag_z > max_z_ff) max_z_in = mag_z;
      end else if (ctrl.finish) begin
         off_x_in = midpoint(min_x_ff, max_x_ff);
         off_y_in = midpoint(min_y_ff, max_y_ff);
         off_z_in = midpoint(min_z_ff, max_z_ff);
      end
   end

   // State registers, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= '0;
         min_y_ff <= '0;
         min_z_ff <= '0;
         max_x_ff <= '0;
         max_y_ff <= '0;
         max_z_ff <= '0;
         off_x_ff <= '0;
         off_y_ff <= '0;
         off_z_ff <= '0;
      end else begin
         min_x_ff <= min_x_in;
         min_y_ff <= min_y_in;
         min_z_ff <= min_z_in;
         max_x_ff <= max_x_in;
         max_y_ff <= max_y_in;
         max_z_ff <= max_z_in;
         off_x_ff <= off_x_in;
         off_y_ff <= off_y_in;
         off_z_ff <= off_z_in;
      end
   end

   assign off_x = off_x_ff;
   assign off_y = off_y_ff;
   assign off_z = off_z_ff;

endmodule

[hdl/mhc_cordic.sv]
// Vectoring rotator: one shared shift-and-add stage used once per cycle while iterate is set.
// Depends on mhc_pkg for widths, control struct and the arctangent table.
module mhc_cordic
   import mhc_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  cordic_ctrl_type           ctrl,
   input  logic signed [DIFF_W-1:0]  dx,
   input  logic signed [DIFF_W-1:0]  dy,
   output logic                      last_step,
   output logic signed [ANGLE_W-1:0] angle
);

   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0]  z_ff, z_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic signed [CORDIC_W-1:0] x_load, y_load;
   logic signed [CORDIC_W-1:0] x_shift, y_shift;
   logic signed [ANGLE_W-1:0]  atan_val;

   // Scaled start vector
   assign x_load = {{(CORDIC_W-DIFF_W-DEG_FRAC){dx[DIFF_W-1]}}, dx, {DEG_FRAC{1'b0}}};
   assign y_load = {{(CORDIC_W-DIFF_W-DEG_FRAC){dy[DIFF_W-1]}}, dy, {DEG_FRAC{1'b0}}};

   // Arithmetic shifts round toward minus infinity
   assign x_shift  = x_ff >>> step_ff;
   assign y_shift  = y_ff >>> step_ff;
   assign atan_val = atan_entry(TBL_IDX_W'(step_ff));

   // Load or one rotation step
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      if (ctrl.load) begin
         step_in = '0;
         if (dx < 0) begin
            // Left half plane: turn by half a revolution first
            x_in = -x_load;
            y_in = -y_load;
            z_in = (dy < 0) ? -DEG_180 : DEG_180;
         end else begin
            x_in = x_load;
            y_in = y_load;
            z_in = '0;
         end
      end else if (ctrl.iterate) begin
         step_in = step_ff + 1'b1;
         if (y_ff > 0) begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + atan_val;
         end else begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - atan_val;
         end
      end
   end

   // Datapath registers; only the step counter needs a reset
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign last_step = (step_ff == STEP_W'(CORDIC_STEPS - 1));
   assign angle     = z_ff;

endmodule

[hdl/magnetometer_heading_calibration.sv]
// Top level of the magnetometer heading calibration block.
// Depends on mhc_pkg, mhc_cal_store and mhc_cordic.
//
// Usage:
//   The request channel (req_*) carries one magnetometer sample per transaction,
//   with the mode in tuser: clear calibration, fold a calibration sample, finish
//   calibration (offsets become the midpoints of min and max), or heading sample.
//   The response channel (rsp_*) returns one transaction per request: the heading
//   in 2^-ANGLE_FRAC_BITS degree (zero except in heading mode) and the three
//   offsets as they stand after the request.
// Timing:
//   In calibration modes a request passes the execute and done states; the
//   response is loaded into the output register from the done state.
//   A heading sample passes the execute, iterate, round and done states; the iterate
//   state runs CORDIC_STEPS steps of the single rotator stage, which performs one
//   step per cycle.
//   The block accepts one request at a time; req_tready is high only when the
//   sequencer is idle, from the cycle after the response has been loaded.
// Reset:
//   Synchronous reset clears the extremes, the offsets and the response valid.
// Back-pressure:
//   The response is held in an output register. A new request is taken while it
//   waits; the next response waits in the sequencer until the register is free.
module magnetometer_heading_calibration
   import mhc_pkg::*;
#(
   parameter int CORDIC_STEPS    = CORDIC_STEPS_DEFAULT,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // mag_x[15:0], mag_y[31:16], mag_z[47:32]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // heading[14:0], off_x[30:15], off_y[46:31],
                                    // off_z[62:47], zero[63]
);

   localparam int SHIFT = DEG_FRAC - ANGLE_FRAC_BITS;
   localparam logic [ROUND_W-1:0] HALF    = ROUND_W'(1) << (SHIFT - 1);
   localparam logic [ROUND_W-1:0] LIMIT   = ROUND_W'(360) << ANGLE_FRAC_BITS;
   localparam logic [ROUND_W-1:0] HEAD180 = ROUND_W'(180) << ANGLE_FRAC_BITS;

   state_type               state_ff, state_in;
   mode_type                mode_ff;
   logic signed [MAG_W-1:0] mag_x_ff, mag_y_ff, mag_z_ff;
   logic                    zero_vec_ff, zero_vec_in;
   logic [HEAD_W-1:0]       head_ff, head_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [63:0]             rsp_data_ff;

   cal_ctrl_type            cal_ctrl;
   cordic_ctrl_type         cordic_ctrl;
   logic                    accept;
   logic                    load_rsp;
   logic                    rsp_free;

   logic signed [MAG_W-1:0]   off_x, off_y, off_z;
   logic signed [DIFF_W-1:0]  dx, dy;
   logic                      last_step;
   logic signed [ANGLE_W-1:0] angle;
   logic signed [TOTAL_W-1:0] total;
   logic [ROUND_W-1:0]        total_clamp;
   logic [ROUND_W-1:0]        round_sum;
   logic [ROUND_W-1:0]        round_val;
   logic [ROUND_W-1:0]        head_full;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= mode_type'(req_tuser);
         mag_x_ff <= req_tdata[15:0];
         mag_y_ff <= req_tdata[31:16];
         mag_z_ff <= req_tdata[47:32];
      end
   end

   // Calibration store
   mhc_cal_store u_cal_store (
      .clock (clock),
      .reset (reset),
      .ctrl  (cal_ctrl),
      .mag_x (mag_x_ff),
      .mag_y (mag_y_ff),
      .mag_z (mag_z_ff),
      .off_x (off_x),
      .off_y (off_y),
      .off_z (off_z)
   );

   // Offset-corrected vector for the heading
   assign dx = DIFF_W'(mag_x_ff) - DIFF_W'(off_x);
   assign dy = DIFF_W'(mag_y_ff) - DIFF_W'(off_y);

   mhc_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cordic_ctrl),
      .dx        (dx),
      .dy        (dy),
      .last_step (last_step),
      .angle     (angle)
   );

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = (mode_ff == MODE_HEADING) ? ST_ITER : ST_DONE;
         end
         ST_ITER: begin
            if (last_step) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_tready          = 1'b0;
      cal_ctrl            = '0;
      cordic_ctrl         = '0;
      load_rsp            = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_EXEC: begin
            unique case (mode_ff)
               MODE_CLEAR:   cal_ctrl.clear    = 1'b1;
               MODE_FOLD:    cal_ctrl.fold     = 1'b1;
               MODE_FINISH:  cal_ctrl.finish   = 1'b1;
               MODE_HEADING: cordic_ctrl.load  = 1'b1;
            endcase
         end
         ST_ITER: begin
            cordic_ctrl.iterate = 1'b1;
         end
         ST_ROUND: begin
         end
         ST_DONE: begin
            load_rsp = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // Shift the angle by 180 degrees, clamp to one revolution and round half up
   assign total = TOTAL_W'(angle) + TOTAL_W'(DEG_180);

   always_comb begin
      if (total < 0) begin
         total_clamp = '0;
      end else if (total > DEG_360) begin
         total_clamp = ROUND_W'(DEG_360);
      end else begin
         total_clamp = total[ROUND_W-1:0];
      end
      round_sum = total_clamp + HALF;
      round_val = round_sum >> SHIFT;
      head_full = (round_val > LIMIT) ? LIMIT : round_val;
   end

   // Heading register; the zero vector reads as exactly 180 degrees
   always_comb begin
      zero_vec_in = zero_vec_ff;
      head_in     = head_ff;
      if (cordic_ctrl.load) begin
         zero_vec_in = (dx == '0) && (dy == '0);
      end
      if (state_ff == ST_ROUND) begin
         head_in = zero_vec_ff ? HEAD180[HEAD_W-1:0] : head_full[HEAD_W-1:0];
      end
      if (cal_ctrl.clear || cal_ctrl.fold || cal_ctrl.finish) begin
         head_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      zero_vec_ff <= zero_vec_in;
      head_ff     <= head_in;
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Response register
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_rsp) begin
         rsp_data_ff <= {1'b0, off_z, off_y, off_x, head_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hdl/mhc_checker.sv]
// Port-level checker for the magnetometer heading calibration block, with its bind.
// Depends on mhc_pkg and on the top level's port list.
module mhc_checker
   import mhc_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEFAULT
)
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   localparam logic [HEAD_W:0] LIMIT = (HEAD_W + 1)'(360) << ANGLE_FRAC_BITS;

   // No response is pending straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // One request at a time: the block is busy after taking a transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // Heading never exceeds one full revolution; checked only for ANGLE_FRAC_BITS up to 6
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ANGLE_FRAC_BITS > 6) || ({1'b0, rsp_tdata[14:0]} <= LIMIT))
      else $error("heading out of range");

endmodule

bind magnetometer_heading_calibration mhc_checker #(
   .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_mhc_checker (.*);
